// File: rtl/pclip_pkg.sv
// ----------------------------------------------------------------------------
// pclip_pkg
// shared types and codes for the polygon clip next-edge decider
// ----------------------------------------------------------------------------
package pclip_pkg;

    localparam int unsigned SideW = 2;
    localparam int unsigned KindW = 2;
    localparam int unsigned EdgeW = 3;

    typedef logic [SideW-1:0] side_t;
    typedef logic [KindW-1:0] kind_t;
    typedef logic [EdgeW-1:0] edge_t;

    localparam side_t SIDE_LEFT  = 2'd0;
    localparam side_t SIDE_ON    = 2'd1;
    localparam side_t SIDE_RIGHT = 2'd2;

    localparam kind_t KIND_PROPER      = 2'd0;
    localparam kind_t KIND_SUBJ_DOUBLE = 2'd1;
    localparam kind_t KIND_CLIP_DOUBLE = 2'd2;
    localparam kind_t KIND_BOTH_DOUBLE = 2'd3;

    localparam edge_t GO_NONE   = 3'd0;
    localparam edge_t GO_SUBJ   = 3'd1;
    localparam edge_t GO_CLIP   = 3'd2;
    localparam edge_t GO_EITHER = 3'd3;
    localparam edge_t GO_ALT    = 3'd4;

    typedef struct packed {
        kind_t cross_kind;
        side_t m_vs_ij;
        side_t n_vs_ij;
        side_t k_vs_ij;
        side_t m_vs_jk;
        side_t n_vs_jk;
        side_t o_vs_ij;
        side_t o_vs_jk;
        side_t o_vs_mn;
        side_t k_vs_mn;
        side_t k_vs_no;
        logic  edges_opposed;
    } crossing_t;

    typedef struct packed {
        edge_t next_edge;
    } decision_t;

endpackage

// File: rtl/pclip_if.sv
// ----------------------------------------------------------------------------
// pclip channel interfaces
// valid/ready channels for crossings in and decisions out
// ----------------------------------------------------------------------------
interface pclip_cross_if;
    logic                 valid;
    logic                 ready;
    pclip_pkg::crossing_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pclip_edge_if;
    logic                 valid;
    logic                 ready;
    pclip_pkg::decision_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/polygon_clip_next_edge_decider.sv
// ----------------------------------------------------------------------------
// polygon_clip_next_edge_decider
// next-edge decision, unless stalled, for one polygon clipping crossing per cycle
// ----------------------------------------------------------------------------
// Takes one crossing per clock cycle while the output is not stalled and
// returns one decision per crossing, in order. A crossing is captured in an
// input register, the decision table is evaluated from that register and
// the result is held in an output register, so a decision becomes valid
// once it has passed through both registers. Each register keeps its item
// until the next stage takes it, so a stalled output holds at most two items
// and the input stays ready while the output register can drain.
// ----------------------------------------------------------------------------
module polygon_clip_next_edge_decider (
    input logic               clk,
    input logic               rst_n,
    pclip_cross_if.sink       crossing,
    pclip_edge_if.source      decision
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    pclip_pkg::crossing_t in_data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    pclip_pkg::edge_t     out_edge_reg;
    pclip_pkg::edge_t     table_edge;
    logic                 in_xfer;
    logic                 out_load;

    pclip_decide u_decide (
        .crossing  (in_data_reg),
        .next_edge (table_edge)
    );

    assign out_load       = in_valid_reg && (!out_valid_reg || decision.ready);
    assign crossing.ready = !in_valid_reg || out_load;
    assign in_xfer        = crossing.valid && crossing.ready;

    always_comb
    begin
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (decision.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_data_reg <= crossing.data;
        end
        if (out_load)
        begin
            out_edge_reg <= table_edge;
        end
    end

    assign decision.valid          = out_valid_reg;
    assign decision.data.next_edge = out_edge_reg;

endmodule

// File: rtl/pclip_decide.sv
// ----------------------------------------------------------------------------
// pclip_decide
// decision table: picks the boundary to follow after one crossing
// ----------------------------------------------------------------------------
module pclip_decide (
    input  pclip_pkg::crossing_t crossing,
    output pclip_pkg::edge_t     next_edge
);

    pclip_pkg::side_t m_ij;
    pclip_pkg::side_t n_ij;
    pclip_pkg::side_t k_ij;
    pclip_pkg::side_t m_jk;
    pclip_pkg::side_t n_jk;
    pclip_pkg::side_t o_ij;
    pclip_pkg::side_t o_jk;
    pclip_pkg::side_t o_mn;
    pclip_pkg::side_t k_mn;
    pclip_pkg::side_t k_no;
    logic             opp;

    pclip_pkg::edge_t go_proper;
    pclip_pkg::edge_t go_subj;
    pclip_pkg::edge_t go_clip;
    pclip_pkg::edge_t go_both;

    logic lr;
    logic rl;
    logic oo;
    logic o_in_l;
    logic o_on_l;
    logic o_in_r;
    logic o_on_r;
    logic m_in_r;

    assign m_ij = crossing.m_vs_ij;
    assign n_ij = crossing.n_vs_ij;
    assign k_ij = crossing.k_vs_ij;
    assign m_jk = crossing.m_vs_jk;
    assign n_jk = crossing.n_vs_jk;
    assign o_ij = crossing.o_vs_ij;
    assign o_jk = crossing.o_vs_jk;
    assign o_mn = crossing.o_vs_mn;
    assign k_mn = crossing.k_vs_mn;
    assign k_no = crossing.k_vs_no;
    assign opp  = crossing.edges_opposed;

    assign lr = (m_ij == pclip_pkg::SIDE_LEFT) && (n_ij == pclip_pkg::SIDE_RIGHT);
    assign rl = (m_ij == pclip_pkg::SIDE_RIGHT) && (n_ij == pclip_pkg::SIDE_LEFT);
    assign oo = (m_ij == pclip_pkg::SIDE_ON) && (n_ij == pclip_pkg::SIDE_ON);

    assign o_in_l = (o_ij == pclip_pkg::SIDE_LEFT) && (o_jk == pclip_pkg::SIDE_LEFT);
    assign o_on_l = (o_ij == pclip_pkg::SIDE_LEFT) && (o_jk == pclip_pkg::SIDE_ON);
    assign o_in_r = (o_ij == pclip_pkg::SIDE_LEFT) || (o_jk == pclip_pkg::SIDE_LEFT);
    assign o_on_r = (o_ij == pclip_pkg::SIDE_RIGHT) && (o_jk == pclip_pkg::SIDE_ON);
    assign m_in_r = (m_ij == pclip_pkg::SIDE_LEFT) || (m_jk == pclip_pkg::SIDE_LEFT);

    // proper crossing
    always_comb
    begin
        if (lr)
        begin
            go_proper = pclip_pkg::GO_SUBJ;
        end
        else if (rl)
        begin
            go_proper = pclip_pkg::GO_CLIP;
        end
        else
        begin
            go_proper = pclip_pkg::GO_NONE;
        end
    end

    // subject vertex on the clip edge
    always_comb
    begin
        if (lr)
        begin
            if (k_ij == pclip_pkg::SIDE_LEFT)
            begin
                go_subj = (m_jk == pclip_pkg::SIDE_LEFT) ? pclip_pkg::GO_SUBJ
                                                         : pclip_pkg::GO_NONE;
            end
            else
            begin
                go_subj = (n_jk == pclip_pkg::SIDE_LEFT) ? pclip_pkg::GO_CLIP
                                                         : pclip_pkg::GO_SUBJ;
            end
        end
        else if (rl)
        begin
            if (k_ij == pclip_pkg::SIDE_LEFT)
            begin
                go_subj = (n_jk == pclip_pkg::SIDE_LEFT) ? pclip_pkg::GO_CLIP
                                                         : pclip_pkg::GO_SUBJ;
            end
            else
            begin
                go_subj = pclip_pkg::GO_CLIP;
            end
        end
        else if (oo)
        begin
            if (opp)
            begin
                go_subj = (k_ij == pclip_pkg::SIDE_RIGHT) ? pclip_pkg::GO_SUBJ
                                                          : pclip_pkg::GO_NONE;
            end
            else
            begin
                go_subj = (k_ij == pclip_pkg::SIDE_LEFT) ? pclip_pkg::GO_SUBJ
                                                         : pclip_pkg::GO_CLIP;
            end
        end
        else
        begin
            go_subj = pclip_pkg::GO_NONE;
        end
    end

    // clip vertex on the subject edge
    always_comb
    begin
        if (m_ij == pclip_pkg::SIDE_LEFT)
        begin
            if (o_ij == pclip_pkg::SIDE_LEFT)
            begin
                go_clip = (o_mn == pclip_pkg::SIDE_LEFT) ? pclip_pkg::GO_CLIP
                                                         : pclip_pkg::GO_NONE;
            end
            else
            begin
                go_clip = pclip_pkg::GO_SUBJ;
            end
        end
        else if (m_ij == pclip_pkg::SIDE_RIGHT)
        begin
            if (o_ij == pclip_pkg::SIDE_LEFT)
            begin
                go_clip = pclip_pkg::GO_CLIP;
            end
            else
            begin
                go_clip = (o_mn == pclip_pkg::SIDE_RIGHT) ? pclip_pkg::GO_SUBJ
                                                          : pclip_pkg::GO_NONE;
            end
        end
        else if (o_ij == pclip_pkg::SIDE_LEFT)
        begin
            go_clip = pclip_pkg::GO_CLIP;
        end
        else
        begin
            go_clip = opp ? pclip_pkg::GO_NONE : pclip_pkg::GO_SUBJ;
        end
    end

    // both vertices double
    always_comb
    begin
        if (k_ij == pclip_pkg::SIDE_LEFT)
        begin
            if (o_mn == pclip_pkg::SIDE_LEFT)
            begin
                if (o_in_l)
                begin
                    go_both = pclip_pkg::GO_CLIP;
                end
                else if (o_on_l)
                begin
                    go_both = pclip_pkg::GO_EITHER;
                end
                else if ((k_mn == pclip_pkg::SIDE_LEFT) && (k_no == pclip_pkg::SIDE_LEFT))
                begin
                    go_both = pclip_pkg::GO_SUBJ;
                end
                else
                begin
                    go_both = pclip_pkg::GO_NONE;
                end
            end
            else if (o_mn == pclip_pkg::SIDE_ON)
            begin
                if (o_in_l)
                begin
                    go_both = pclip_pkg::GO_CLIP;
                end
                else if (o_on_l)
                begin
                    go_both = pclip_pkg::GO_EITHER;
                end
                else if (k_no == pclip_pkg::SIDE_LEFT)
                begin
                    go_both = pclip_pkg::GO_SUBJ;
                end
                else
                begin
                    go_both = pclip_pkg::GO_NONE;
                end
            end
            else if (o_in_l)
            begin
                go_both = ((m_ij == pclip_pkg::SIDE_LEFT) && (m_jk == pclip_pkg::SIDE_LEFT))
                          ? pclip_pkg::GO_ALT : pclip_pkg::GO_CLIP;
            end
            else if (o_on_l)
            begin
                go_both = pclip_pkg::GO_EITHER;
            end
            else if ((m_ij != pclip_pkg::SIDE_RIGHT) && (m_jk != pclip_pkg::SIDE_RIGHT))
            begin
                go_both = pclip_pkg::GO_SUBJ;
            end
            else
            begin
                go_both = pclip_pkg::GO_NONE;
            end
        end
        else if (k_ij == pclip_pkg::SIDE_ON)
        begin
            if (o_mn == pclip_pkg::SIDE_LEFT)
            begin
                if (o_ij == pclip_pkg::SIDE_LEFT)
                begin
                    go_both = pclip_pkg::GO_CLIP;
                end
                else if ((o_ij == pclip_pkg::SIDE_ON) && (m_ij == pclip_pkg::SIDE_LEFT))
                begin
                    go_both = pclip_pkg::GO_EITHER;
                end
                else if ((k_mn == pclip_pkg::SIDE_LEFT) && (k_no == pclip_pkg::SIDE_LEFT))
                begin
                    go_both = pclip_pkg::GO_SUBJ;
                end
                else
                begin
                    go_both = pclip_pkg::GO_NONE;
                end
            end
            else if (o_mn == pclip_pkg::SIDE_ON)
            begin
                if (o_ij == pclip_pkg::SIDE_LEFT)
                begin
                    go_both = pclip_pkg::GO_CLIP;
                end
                else if (o_ij == pclip_pkg::SIDE_ON)
                begin
                    go_both = opp ? pclip_pkg::GO_NONE : pclip_pkg::GO_EITHER;
                end
                else
                begin
                    go_both = pclip_pkg::GO_SUBJ;
                end
            end
            else if (o_ij == pclip_pkg::SIDE_LEFT)
            begin
                go_both = (m_ij == pclip_pkg::SIDE_LEFT) ? pclip_pkg::GO_ALT
                                                         : pclip_pkg::GO_CLIP;
            end
            else if (o_ij == pclip_pkg::SIDE_ON)
            begin
                go_both = opp ? pclip_pkg::GO_SUBJ : pclip_pkg::GO_EITHER;
            end
            else
            begin
                go_both = pclip_pkg::GO_SUBJ;
            end
        end
        else
        begin
            if (o_in_r)
            begin
                go_both = m_in_r ? pclip_pkg::GO_ALT : pclip_pkg::GO_CLIP;
            end
            else if (o_on_r)
            begin
                go_both = pclip_pkg::GO_EITHER;
            end
            else if (o_mn == pclip_pkg::SIDE_LEFT)
            begin
                go_both = m_in_r ? pclip_pkg::GO_SUBJ : pclip_pkg::GO_NONE;
            end
            else
            begin
                go_both = pclip_pkg::GO_SUBJ;
            end
        end
    end

    always_comb
    begin
        case (crossing.cross_kind)
            pclip_pkg::KIND_PROPER:      next_edge = go_proper;
            pclip_pkg::KIND_SUBJ_DOUBLE: next_edge = go_subj;
            pclip_pkg::KIND_CLIP_DOUBLE: next_edge = go_clip;
            pclip_pkg::KIND_BOTH_DOUBLE: next_edge = go_both;
            default:                     next_edge = go_both;
        endcase
    end

endmodule

// File: sim/polygon_clip_next_edge_decider_test.sv
// ----------------------------------------------------------------------------
// polygon_clip_next_edge_decider_test
// self-checking bench for the polygon clip next-edge decider
// ----------------------------------------------------------------------------
// Sends crossings over the input channel and predicts the next-edge decision
// for each accepted crossing with an independent decision table. Every
// decision coming out is checked in order against the oldest prediction.
// Directed crossings cover each kind, the edge codes and the unused
// orientation code. Random crossings follow, back to back, one at a time
// and with idle gaps on the sending side and stalls on the receiving side.
// ----------------------------------------------------------------------------
module polygon_clip_next_edge_decider_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pclip_pkg::*;

    localparam side_t SL = SIDE_LEFT;
    localparam side_t SO = SIDE_ON;
    localparam side_t SR = SIDE_RIGHT;
    localparam side_t SX = 2'd3;

    localparam int unsigned CycleLimit = 400_000;

    typedef struct {
        crossing_t crossing;
        edge_t     go;
    } pending_decision_t;

    logic clk;
    logic rst_n;

    pclip_cross_if cross_ch ();
    pclip_edge_if  dec_ch ();

    polygon_clip_next_edge_decider dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .crossing (cross_ch),
        .decision (dec_ch)
    );

    pending_decision_t pending_decisions[$];
    int unsigned       cycle_count;
    int unsigned       mismatch_count;
    int unsigned       crossings_sent;
    int unsigned       kind_hits[4];
    int unsigned       edge_hits[5];
    int unsigned       bad_code_hits;
    int unsigned       stall_left;
    bit                source_gaps;
    bit                sink_stalls;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // next-edge decision table
    function automatic edge_t next_edge_for(crossing_t c);
        logic  o_in;
        logic  o_on;
        logic  m_in;
        edge_t go;
        go = GO_NONE;
        case (c.cross_kind)
            KIND_PROPER:
            begin
                if (c.m_vs_ij == SL && c.n_vs_ij == SR)
                    go = GO_SUBJ;
                else if (c.m_vs_ij == SR && c.n_vs_ij == SL)
                    go = GO_CLIP;
            end
            KIND_SUBJ_DOUBLE:
            begin
                if (c.m_vs_ij == SL && c.n_vs_ij == SR)
                begin
                    if (c.k_vs_ij == SL)
                        go = (c.m_vs_jk == SL) ? GO_SUBJ : GO_NONE;
                    else
                        go = (c.n_vs_jk == SL) ? GO_CLIP : GO_SUBJ;
                end
                else if (c.m_vs_ij == SR && c.n_vs_ij == SL)
                begin
                    if (c.k_vs_ij == SL)
                        go = (c.n_vs_jk == SL) ? GO_CLIP : GO_SUBJ;
                    else
                        go = GO_CLIP;
                end
                else if (c.m_vs_ij == SO && c.n_vs_ij == SO)
                begin
                    if (c.edges_opposed)
                        go = (c.k_vs_ij == SR) ? GO_SUBJ : GO_NONE;
                    else
                        go = (c.k_vs_ij == SL) ? GO_SUBJ : GO_CLIP;
                end
            end
            KIND_CLIP_DOUBLE:
            begin
                if (c.m_vs_ij == SL)
                begin
                    if (c.o_vs_ij == SL)
                        go = (c.o_vs_mn == SL) ? GO_CLIP : GO_NONE;
                    else
                        go = GO_SUBJ;
                end
                else if (c.m_vs_ij == SR)
                begin
                    if (c.o_vs_ij == SL)
                        go = GO_CLIP;
                    else
                        go = (c.o_vs_mn == SR) ? GO_SUBJ : GO_NONE;
                end
                else if (c.o_vs_ij == SL)
                    go = GO_CLIP;
                else
                    go = c.edges_opposed ? GO_NONE : GO_SUBJ;
            end
            default:
            begin
                if (c.k_vs_ij == SL)
                begin
                    o_in = (c.o_vs_ij == SL && c.o_vs_jk == SL);
                    o_on = (c.o_vs_ij == SL && c.o_vs_jk == SO);
                    if (c.o_vs_mn == SL)
                    begin
                        if (o_in)
                            go = GO_CLIP;
                        else if (o_on)
                            go = GO_EITHER;
                        else
                            go = (c.k_vs_mn == SL && c.k_vs_no == SL) ? GO_SUBJ : GO_NONE;
                    end
                    else if (c.o_vs_mn == SO)
                    begin
                        if (o_in)
                            go = GO_CLIP;
                        else if (o_on)
                            go = GO_EITHER;
                        else
                            go = (c.k_vs_no == SL) ? GO_SUBJ : GO_NONE;
                    end
                    else if (o_in)
                        go = (c.m_vs_ij == SL && c.m_vs_jk == SL) ? GO_ALT : GO_CLIP;
                    else if (o_on)
                        go = GO_EITHER;
                    else
                        go = (c.m_vs_ij != SR && c.m_vs_jk != SR) ? GO_SUBJ : GO_NONE;
                end
                else if (c.k_vs_ij == SO)
                begin
                    if (c.o_vs_mn == SL)
                    begin
                        if (c.o_vs_ij == SL)
                            go = GO_CLIP;
                        else if (c.o_vs_ij == SO && c.m_vs_ij == SL)
                            go = GO_EITHER;
                        else
                            go = (c.k_vs_mn == SL && c.k_vs_no == SL) ? GO_SUBJ : GO_NONE;
                    end
                    else if (c.o_vs_mn == SO)
                    begin
                        if (c.o_vs_ij == SL)
                            go = GO_CLIP;
                        else if (c.o_vs_ij == SO)
                            go = c.edges_opposed ? GO_NONE : GO_EITHER;
                        else
                            go = GO_SUBJ;
                    end
                    else if (c.o_vs_ij == SL)
                        go = (c.m_vs_ij == SL) ? GO_ALT : GO_CLIP;
                    else if (c.o_vs_ij == SO)
                        go = c.edges_opposed ? GO_SUBJ : GO_EITHER;
                    else
                        go = GO_SUBJ;
                end
                else
                begin
                    o_in = (c.o_vs_ij == SL || c.o_vs_jk == SL);
                    o_on = (c.o_vs_ij == SR && c.o_vs_jk == SO);
                    m_in = (c.m_vs_ij == SL || c.m_vs_jk == SL);
                    if (o_in)
                        go = m_in ? GO_ALT : GO_CLIP;
                    else if (o_on)
                        go = GO_EITHER;
                    else if (c.o_vs_mn == SL)
                        go = m_in ? GO_SUBJ : GO_NONE;
                    else
                        go = GO_SUBJ;
                end
            end
        endcase
        return go;
    endfunction

    function automatic crossing_t make_crossing(kind_t kind, side_t m_ij, side_t n_ij,
                                                side_t k_ij, side_t m_jk, side_t n_jk,
                                                side_t o_ij, side_t o_jk, side_t o_mn,
                                                side_t k_mn, side_t k_no, logic opp);
        crossing_t c;
        c.cross_kind    = kind;
        c.m_vs_ij       = m_ij;
        c.n_vs_ij       = n_ij;
        c.k_vs_ij       = k_ij;
        c.m_vs_jk       = m_jk;
        c.n_vs_jk       = n_jk;
        c.o_vs_ij       = o_ij;
        c.o_vs_jk       = o_jk;
        c.o_vs_mn       = o_mn;
        c.k_vs_mn       = k_mn;
        c.k_vs_no       = k_no;
        c.edges_opposed = opp;
        return c;
    endfunction

    // mostly legal codes, now and then the unused code
    function automatic side_t random_side();
        if ($urandom_range(0, 9) == 0)
            return side_t'($urandom_range(SL, SX));
        return side_t'($urandom_range(SL, SR));
    endfunction

    function automatic crossing_t random_crossing();
        int unsigned pick;
        kind_t       kind;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            kind = KIND_BOTH_DOUBLE;
        else
            kind = kind_t'($urandom_range(KIND_PROPER, KIND_CLIP_DOUBLE));
        return make_crossing(kind, random_side(), random_side(), random_side(),
                             random_side(), random_side(), random_side(), random_side(),
                             random_side(), random_side(), random_side(),
                             logic'($urandom_range(0, 1)));
    endfunction

    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return $urandom_range(1, 3);
        if (pick < 95)
            return $urandom_range(4, 8);
        return $urandom_range(12, 30);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_crossing(crossing_t c, int unsigned gap);
        pending_decision_t due;
        cross_ch.data  = c;
        cross_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!cross_ch.ready);
        due.crossing = c;
        due.go       = next_edge_for(c);
        pending_decisions = {pending_decisions, due};
        crossings_sent++;
        kind_hits[c.cross_kind]++;
        edge_hits[due.go]++;
        if (c.m_vs_ij == SX || c.n_vs_ij == SX || c.k_vs_ij == SX || c.m_vs_jk == SX
            || c.n_vs_jk == SX || c.o_vs_ij == SX || c.o_vs_jk == SX || c.o_vs_mn == SX
            || c.k_vs_mn == SX || c.k_vs_no == SX)
            bad_code_hits++;
        @(negedge clk);
        if (gap > 0)
        begin
            cross_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_random(crossing_t c);
        int unsigned gap;
        gap = 0;
        if (source_gaps && $urandom_range(0, 99) < 30)
            gap = idle_length();
        send_crossing(c, gap);
    endtask

    task automatic wait_for_decisions();
        while (pending_decisions.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_random('0);
        send_random('1);
        // proper crossings, some with unused fields held at the unused code
        send_random(make_crossing(KIND_PROPER, SL, SR, SX, SX, SX,
                                  SX, SX, SX, SX, SX, 1'b1));
        send_random(make_crossing(KIND_PROPER, SR, SL, SX, SX, SX,
                                  SX, SX, SX, SX, SX, 1'b1));
        send_random(make_crossing(KIND_PROPER, SL, SL, SL, SL, SL,
                                  SL, SL, SL, SL, SL, 1'b0));
        send_random(make_crossing(KIND_PROPER, SX, SL, SL, SL, SL,
                                  SL, SL, SL, SL, SL, 1'b0));
        // subject vertex double
        send_random(make_crossing(KIND_SUBJ_DOUBLE, SL, SR, SL, SL, SR,
                                  SX, SX, SX, SX, SX, 1'b0));
        send_random(make_crossing(KIND_SUBJ_DOUBLE, SL, SR, SR, SR, SL,
                                  SL, SL, SL, SL, SL, 1'b0));
        send_random(make_crossing(KIND_SUBJ_DOUBLE, SR, SL, SL, SL, SX,
                                  SL, SL, SL, SL, SL, 1'b0));
        send_random(make_crossing(KIND_SUBJ_DOUBLE, SO, SO, SR, SL, SL,
                                  SL, SL, SL, SL, SL, 1'b1));
        send_random(make_crossing(KIND_SUBJ_DOUBLE, SO, SO, SX, SL, SL,
                                  SL, SL, SL, SL, SL, 1'b0));
        send_random(make_crossing(KIND_SUBJ_DOUBLE, SL, SO, SL, SL, SL,
                                  SL, SL, SL, SL, SL, 1'b0));
        // clip vertex double
        send_random(make_crossing(KIND_CLIP_DOUBLE, SL, SX, SX, SX, SX,
                                  SL, SX, SL, SX, SX, 1'b0));
        send_random(make_crossing(KIND_CLIP_DOUBLE, SR, SL, SL, SL, SL,
                                  SR, SL, SR, SL, SL, 1'b0));
        send_random(make_crossing(KIND_CLIP_DOUBLE, SX, SL, SL, SL, SL,
                                  SX, SL, SL, SL, SL, 1'b1));
        send_random(make_crossing(KIND_CLIP_DOUBLE, SO, SL, SL, SL, SL,
                                  SO, SL, SL, SL, SL, 1'b0));
        // both double
        send_random(make_crossing(KIND_BOTH_DOUBLE, SL, SL, SL, SL, SL,
                                  SL, SL, SR, SL, SL, 1'b0));
        send_random(make_crossing(KIND_BOTH_DOUBLE, SL, SL, SL, SL, SL,
                                  SL, SO, SL, SL, SL, 1'b0));
        send_random(make_crossing(KIND_BOTH_DOUBLE, SL, SL, SO, SL, SL,
                                  SO, SL, SO, SL, SL, 1'b0));
        send_random(make_crossing(KIND_BOTH_DOUBLE, SR, SL, SX, SR, SL,
                                  SR, SO, SL, SL, SL, 1'b0));
        send_random(make_crossing(KIND_BOTH_DOUBLE, SR, SL, SX, SR, SL,
                                  SR, SR, SL, SL, SL, 1'b0));
        send_random(make_crossing(KIND_BOTH_DOUBLE, SL, SL, SL, SL, SL,
                                  SX, SX, SX, SX, SX, 1'b1));
        send_random(make_crossing(KIND_BOTH_DOUBLE, SL, SL, SO, SL, SL,
                                  SX, SL, SX, SL, SL, 1'b1));
        cross_ch.valid = 1'b0;
    endtask

    task automatic test_back_to_back();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        repeat (200) send_random(random_crossing());
        cross_ch.valid = 1'b0;
    endtask

    task automatic test_one_at_a_time();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        repeat (30)
        begin
            send_crossing(random_crossing(), 1);
            wait_for_decisions();
        end
    endtask

    task automatic test_random();
        for (int i = 0; i < 1000; i++)
        begin
            if (i % 100 == 0)
            begin
                source_gaps = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
            end
            send_random(random_crossing());
        end
        cross_ch.valid = 1'b0;
    endtask

    // receiver with random stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            dec_ch.ready = 1'b0;
            stall_left--;
        end
        else if (sink_stalls && $urandom_range(0, 99) < 25)
        begin
            dec_ch.ready = 1'b0;
            stall_left   = idle_length() - 1;
        end
        else
            dec_ch.ready = 1'b1;
    end

    // check each decision transfer against the oldest prediction
    always @(posedge clk)
    begin
        pending_decision_t due;
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout with %0d decisions outstanding", pending_decisions.size());
            $display("FAIL");
            $finish;
        end
        else if (rst_n && dec_ch.valid === 1'b1 && dec_ch.ready === 1'b1)
        begin
            if (pending_decisions.size() == 0)
                report_mismatch($sformatf("decision %0d with no crossing outstanding",
                                          dec_ch.data.next_edge));
            else
            begin
                due = pending_decisions.pop_front();
                if (dec_ch.data.next_edge !== due.go)
                    report_mismatch($sformatf("crossing %h: next_edge %0d, predicted %0d",
                                              due.crossing, dec_ch.data.next_edge, due.go));
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cross_ch.valid = 1'b0;
        cross_ch.data  = '0;
        dec_ch.ready   = 1'b0;
        stall_left     = 0;
        source_gaps    = 1'b1;
        sink_stalls    = 1'b1;
        cycle_count    = 0;
        mismatch_count = 0;
        crossings_sent = 0;
        bad_code_hits  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_back_to_back();
        test_one_at_a_time();
        test_random();

        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d crossings (kinds %0d/%0d/%0d/%0d), %0d with the unused side code",
                 crossings_sent, kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3],
                 bad_code_hits);
        $display("decisions none %0d subject %0d clip %0d either %0d alternate %0d",
                 edge_hits[0], edge_hits[1], edge_hits[2], edge_hits[3], edge_hits[4]);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/pclip_pkg.sv
rtl/pclip_if.sv
rtl/pclip_decide.sv
rtl/polygon_clip_next_edge_decider.sv
sim/polygon_clip_next_edge_decider_test.sv
